@@ sv/dtq_pkg.sv @@
// Package: constants, types and codes for the deadline timer queue.
`default_nettype none
package dtq_pkg;
	localparam int CAPACITY  = 16;
	localparam int TIME_BITS = 48;
	localparam int IDX_BITS  = $clog2(CAPACITY);
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);
	localparam int SEQ_BITS  = 16;
	localparam int TICK_BITS = 32;
	localparam logic [TICK_BITS-1:0] TICK_RESET = 32'd1000;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_FIRED = 2'd1,
		KIND_WAKE  = 2'd2
	} kind_t;

	localparam logic CMD_SCHEDULE = 1'b0;
	localparam logic CMD_TICK     = 1'b1;

	typedef struct packed {
		logic [TIME_BITS-1:0] deadline;
		logic [7:0]           id;
		logic [SEQ_BITS-1:0]  seq;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_MOVE,
		ST_OUT
	} state_t;

	function automatic logic [TIME_BITS-1:0] sat_add(
		input logic [TIME_BITS-1:0] a, input logic [TICK_BITS-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {{(TIME_BITS + 1 - TICK_BITS){1'b0}}, b};
		return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
	endfunction

	function automatic logic earlier(input entry_t a, input entry_t b);
		logic [SEQ_BITS-1:0] d;
		d = a.seq - b.seq;
		if (a.deadline != b.deadline)
			return a.deadline < b.deadline;
		return d[SEQ_BITS-1];
	endfunction
endpackage
`default_nettype wire

@@ sv/dtq_if.sv @@
// Interfaces: input and result channels of the deadline timer queue.
`default_nettype none
interface dtq_in_if import dtq_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic                 cmd;
	logic [7:0]           event_id;
	logic [TIME_BITS-1:0] time_value;
	modport source (output valid, cmd, event_id, time_value, input ready);
	modport sink (input valid, cmd, event_id, time_value, output ready);
endinterface

interface dtq_out_if import dtq_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic [1:0]           kind;
	logic                 status;
	logic [7:0]           fired_id;
	logic [TIME_BITS-1:0] fired_deadline;
	logic                 wake_request;
	logic [TIME_BITS-1:0] next_wake;
	logic                 last;
	modport source (output valid, kind, status, fired_id, fired_deadline,
		wake_request, next_wake, last, input ready);
	modport sink (input valid, kind, status, fired_id, fired_deadline,
		wake_request, next_wake, last, output ready);
endinterface
`default_nettype wire

@@ sv/dtq_store.sv @@
// Entry memory: one write port, one read port, registered read data.
`default_nettype none
module dtq_store import dtq_pkg::*; (
	input  wire logic                clk,
	input  wire logic                we,
	input  wire logic [IDX_BITS-1:0] waddr,
	input  wire entry_t              wdata,
	input  wire logic [IDX_BITS-1:0] raddr,
	output entry_t                   rdata
);
	entry_t mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ sv/deadline_timer_queue.sv @@
// Top level: deadline timer queue with memory-held entries and a sequencer.
// Usage:
//   in  : schedule (cmd 0: event_id, deadline) or tick (cmd 1: current time).
//   out : one ack per schedule; per tick, each expired event in deadline
//         order (ties by insertion order) then one wake report; last marks
//         the final result of an input.
//   The user writes tick_len (cfg_we/cfg_data) only while the block is idle.
// Timing:
//   A schedule is acknowledged in the cycle after its transfer. A tick scans
//   the entry memory once per fired event and once more for the report: each
//   scan reads one entry per cycle over the entries still held, and each
//   fired event adds a move of the last entry into its slot. The entry memory
//   has a single read port. One input is handled at a time. The block does
//   not enforce that tick_len is written only while idle.
// Reset:
//   arst_n clears count, sequence, armed wake and tick_len (1000); the
//   memory contents need no clearing.
// Stall:
//   Each result is held in an output register until its transfer; the
//   sequencer waits while out.ready is low.
`default_nettype none
module deadline_timer_queue import dtq_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [TICK_BITS-1:0] cfg_data,
	dtq_in_if.sink                    in,
	dtq_out_if.source                 out
);
	state_t state_q, state_d;
	logic [TICK_BITS-1:0] tick_len_q;
	logic [CNT_BITS-1:0]  count_q;
	logic [SEQ_BITS-1:0]  seq_q;
	logic [TIME_BITS-1:0] armed_q;
	logic [TIME_BITS-1:0] now_q;
	logic [CNT_BITS-1:0]  scan_q;
	logic                 rd_valid_s1;
	logic [IDX_BITS-1:0]  rd_idx_s1;
	logic                 best_ok_q;
	entry_t               best_q;
	logic [IDX_BITS-1:0]  best_idx_q;

	logic                 mem_we;
	logic [IDX_BITS-1:0]  mem_waddr;
	entry_t               mem_wdata;
	logic [IDX_BITS-1:0]  mem_raddr;
	entry_t               mem_rdata;

	logic                 ovalid_q;
	logic [1:0]           okind_q;
	logic                 ostatus_q;
	logic [7:0]           oid_q;
	logic [TIME_BITS-1:0] odl_q;
	logic                 owreq_q;
	logic [TIME_BITS-1:0] owake_q;
	logic                 olast_q;

	logic in_xfer, out_free, fire_now, out_load, rd_issue;
	logic [TIME_BITS-1:0] soon, wake_val;

	assign in.ready = (state_q == ST_IDLE) && !ovalid_q;
	assign in_xfer  = in.valid && in.ready;
	assign out_free = !ovalid_q || out.ready;
	assign soon     = sat_add(now_q, tick_len_q);
	assign wake_val = (best_q.deadline > soon) ? best_q.deadline : soon;
	assign fire_now = best_ok_q && (best_q.deadline < now_q);
	assign out_load = ((state_q == ST_IDLE) && in_xfer && (in.cmd == CMD_SCHEDULE)) ||
		((state_q == ST_OUT) && out_free);
	assign rd_issue = ((state_q == ST_SCAN) && (scan_q < count_q)) ||
		((state_q == ST_MOVE) && !rd_valid_s1);

	dtq_store u_store (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = best_idx_q;
		mem_wdata = mem_rdata;
		mem_raddr = scan_q[IDX_BITS-1:0];
		if (state_q == ST_IDLE) begin
			mem_we    = in_xfer && (in.cmd == CMD_SCHEDULE) && (count_q < CNT_BITS'(CAPACITY));
			mem_waddr = count_q[IDX_BITS-1:0];
			mem_wdata = '{deadline: in.time_value, id: in.event_id, seq: seq_q};
		end else if (state_q == ST_MOVE) begin
			mem_we = rd_valid_s1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_xfer && in.cmd == CMD_TICK) state_d = ST_SCAN;
			ST_SCAN:     if (scan_q >= count_q) state_d = ST_SCAN_END;
			ST_SCAN_END: if (!rd_valid_s1) state_d = ST_OUT;
			ST_OUT: begin
				if (out_free)
					state_d = fire_now ? ST_MOVE : ST_IDLE;
			end
			ST_MOVE:     if (rd_valid_s1) state_d = ST_SCAN;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_len_q  <= TICK_RESET;
			count_q     <= '0;
			seq_q       <= '0;
			armed_q     <= '0;
			ovalid_q    <= 1'b0;
			rd_valid_s1 <= 1'b0;
			best_ok_q   <= 1'b0;
			scan_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				tick_len_q <= cfg_data;
			ovalid_q    <= out_load || (ovalid_q && !out.ready);
			rd_valid_s1 <= rd_issue;
			rd_idx_s1   <= scan_q[IDX_BITS-1:0];
			unique case (state_q)
				ST_IDLE: begin
					scan_q    <= '0;
					best_ok_q <= 1'b0;
					now_q     <= in.time_value;
					if (in_xfer && in.cmd == CMD_SCHEDULE) begin
						okind_q   <= KIND_ACK;
						oid_q     <= '0;
						odl_q     <= '0;
						owake_q   <= '0;
						olast_q   <= 1'b1;
						if (count_q < CNT_BITS'(CAPACITY)) begin
							ostatus_q <= 1'b0;
							owreq_q   <= (armed_q == '0) ||
								(sat_add(in.time_value, tick_len_q) < armed_q);
							count_q   <= count_q + 1'b1;
							seq_q     <= seq_q + 1'b1;
							armed_q   <= TIME_BITS'(1);
						end else begin
							ostatus_q <= 1'b1;
							owreq_q   <= 1'b0;
						end
					end
				end
				ST_SCAN, ST_SCAN_END: begin
					if (state_q == ST_SCAN && scan_q < count_q) begin
						scan_q      <= scan_q + 1'b1;
					end
					if (rd_valid_s1 && (!best_ok_q || earlier(mem_rdata, best_q))) begin
						best_ok_q  <= 1'b1;
						best_q     <= mem_rdata;
						best_idx_q <= rd_idx_s1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						ostatus_q <= 1'b0;
						owreq_q   <= 1'b0;
						if (fire_now) begin
							okind_q <= KIND_FIRED;
							oid_q   <= best_q.id;
							odl_q   <= best_q.deadline;
							owake_q <= '0;
							olast_q <= 1'b0;
							count_q <= count_q - 1'b1;
							scan_q  <= count_q - 1'b1;
						end else begin
							okind_q <= KIND_WAKE;
							oid_q   <= '0;
							odl_q   <= '0;
							owake_q <= best_ok_q ? wake_val : '0;
							armed_q <= best_ok_q ? wake_val : '0;
							olast_q <= 1'b1;
						end
					end
				end
				ST_MOVE: begin
					if (rd_valid_s1) begin
						scan_q    <= '0;
						best_ok_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign out.valid          = ovalid_q;
	assign out.kind           = okind_q;
	assign out.status         = ostatus_q;
	assign out.fired_id       = oid_q;
	assign out.fired_deadline = odl_q;
	assign out.wake_request   = owreq_q;
	assign out.next_wake      = owake_q;
	assign out.last           = olast_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(CAPACITY)) else $error("entry count above capacity");
	a_fire_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && okind_q == KIND_FIRED |-> !olast_q) else $error("fired marked last");
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in.ready |-> state_q == ST_IDLE) else $error("ready outside idle");
endmodule
`default_nettype wire

@@ tb/tb_deadline_timer_queue.sv @@
// Testbench for deadline_timer_queue: directed table, then random traffic checked by a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_deadline_timer_queue;
	import dtq_pkg::*;

	typedef struct {
		logic [1:0]           kind;
		logic                 status;
		logic [7:0]           fired_id;
		logic [TIME_BITS-1:0] fired_deadline;
		logic                 wake_request;
		logic [TIME_BITS-1:0] next_wake;
		logic                 last;
	} result_t;

	typedef struct {
		logic                 cmd;
		logic [7:0]           id;
		logic [TIME_BITS-1:0] t;
		bit                   typed;
		result_t              want;
	} row_t;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [TICK_BITS-1:0] cfg_data = '0;

	dtq_in_if  in_ch ();
	dtq_out_if out_ch ();

	deadline_timer_queue dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in(in_ch.sink), .out(out_ch.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [TIME_BITS-1:0] q_deadline [CAPACITY];
	logic [7:0]           q_id [CAPACITY];
	logic [SEQ_BITS-1:0]  q_seq [CAPACITY];
	int                   q_count = 0;
	logic [SEQ_BITS-1:0]  seq_next = '0;
	logic [TIME_BITS-1:0] wake_armed = '0;
	logic [TICK_BITS-1:0] tick_gap = TICK_RESET;

	result_t expected_q [$];
	row_t    table_q [$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int fired_seen = 0;
	int rejects_seen = 0;
	int cycles = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	function automatic logic [TIME_BITS-1:0] add_sat(logic [TIME_BITS-1:0] a,
			logic [TICK_BITS-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {{(TIME_BITS + 1 - TICK_BITS){1'b0}}, b};
		return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
	endfunction

	function automatic bit goes_first(int a, int b);
		logic [SEQ_BITS-1:0] d;
		d = q_seq[a] - q_seq[b];
		if (q_deadline[a] != q_deadline[b])
			return q_deadline[a] < q_deadline[b];
		return d[SEQ_BITS-1];
	endfunction

	function automatic int earliest();
		int best;
		best = -1;
		for (int i = 0; i < q_count; i++)
			if (best < 0 || goes_first(i, best))
				best = i;
		return best;
	endfunction

	function automatic result_t mk(logic [1:0] k, logic st, logic [7:0] fid,
			logic [TIME_BITS-1:0] fdl, logic wr, logic [TIME_BITS-1:0] nw, logic lst);
		result_t r;
		r.kind = k; r.status = st; r.fired_id = fid; r.fired_deadline = fdl;
		r.wake_request = wr; r.next_wake = nw; r.last = lst;
		return r;
	endfunction

	// advance the queue model by one input and return the results it causes
	task automatic queue_predict(logic cmd, logic [7:0] id, logic [TIME_BITS-1:0] t,
			ref result_t res [$]);
		int f;
		logic [TIME_BITS-1:0] soon;
		logic [TIME_BITS-1:0] wake;
		logic wr;
		res = {};
		if (cmd == CMD_SCHEDULE) begin
			if (q_count >= CAPACITY) begin
				res = {res, mk(KIND_ACK, 1'b1, '0, '0, 1'b0, '0, 1'b1)};
			end else begin
				wr = (wake_armed == '0) || (add_sat(t, tick_gap) < wake_armed);
				q_deadline[q_count] = t;
				q_id[q_count] = id;
				q_seq[q_count] = seq_next;
				seq_next++;
				q_count++;
				wake_armed = TIME_BITS'(1);
				res = {res, mk(KIND_ACK, 1'b0, '0, '0, wr, '0, 1'b1)};
			end
		end else begin
			forever begin
				f = earliest();
				if (f < 0 || q_deadline[f] >= t)
					break;
				res = {res, mk(KIND_FIRED, 1'b0, q_id[f], q_deadline[f], 1'b0, '0, 1'b0)};
				q_count--;
				q_deadline[f] = q_deadline[q_count];
				q_id[f] = q_id[q_count];
				q_seq[f] = q_seq[q_count];
			end
			f = earliest();
			wake = '0;
			if (f >= 0) begin
				soon = add_sat(t, tick_gap);
				wake = q_deadline[f] > soon ? q_deadline[f] : soon;
			end
			wake_armed = wake;
			res = {res, mk(KIND_WAKE, 1'b0, '0, '0, 1'b0, wake, 1'b1)};
		end
	endtask

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch on result %0d: %s got %0h want %0h", results_seen, field,
			got, want);
		errors++;
	endtask

	// result side
	always @(posedge clk) begin
		result_t w;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_q.size() == 0) begin
				report("unexpected transfer", 64'(out_ch.kind), 64'd0);
			end else begin
				w = expected_q.pop_front();
				if (out_ch.kind !== w.kind)
					report("kind", 64'(out_ch.kind), 64'(w.kind));
				if (out_ch.status !== w.status)
					report("status", 64'(out_ch.status), 64'(w.status));
				if (out_ch.fired_id !== w.fired_id)
					report("fired_id", 64'(out_ch.fired_id), 64'(w.fired_id));
				if (out_ch.fired_deadline !== w.fired_deadline)
					report("fired_deadline", 64'(out_ch.fired_deadline),
						64'(w.fired_deadline));
				if (out_ch.wake_request !== w.wake_request)
					report("wake_request", 64'(out_ch.wake_request), 64'(w.wake_request));
				if (out_ch.next_wake !== w.next_wake)
					report("next_wake", 64'(out_ch.next_wake), 64'(w.next_wake));
				if (out_ch.last !== w.last)
					report("last", 64'(out_ch.last), 64'(w.last));
				if (w.kind == KIND_FIRED) fired_seen++;
				if (w.kind == KIND_ACK && w.status) rejects_seen++;
			end
			results_seen++;
		end
	end

	// receiver readiness: random stall bursts, one long hold-off on request
	initial begin
		int burst;
		int held;
		burst = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				held = 0;
				out_ch.ready = 1'b0;
				while (held < HOLD_CYCLES) begin
					@(negedge clk);
					held++;
				end
				hold_req = 1'b0;
				out_ch.ready = 1'b1;
			end else if (quiet || !arst_n) begin
				out_ch.ready = arst_n;
			end else if (burst > 0) begin
				burst--;
				out_ch.ready = 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 12) - 1;
				out_ch.ready = 1'b0;
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic send(logic cmd, logic [7:0] id, logic [TIME_BITS-1:0] t, bit typed,
			result_t want);
		result_t res [$];
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.cmd = cmd;
		in_ch.event_id = id;
		in_ch.time_value = t;
		do @(posedge clk); while (!in_ch.ready);
		queue_predict(cmd, id, t, res);
		if (typed) res[0] = want;
		foreach (res[i]) expected_q = {expected_q, res[i]};
		items_sent++;
		@(negedge clk);
	endtask

	task automatic settle_and_set(logic [TICK_BITS-1:0] v);
		in_ch.valid = 1'b0;
		wait (expected_q.size() == 0);
		repeat (8) @(negedge clk);
		cfg_we = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		tick_gap = v;
	endtask

	function automatic row_t row(logic cmd, logic [7:0] id, logic [TIME_BITS-1:0] t,
			bit typed, result_t want);
		row_t r;
		r.cmd = cmd; r.id = id; r.t = t; r.typed = typed; r.want = want;
		return r;
	endfunction

	initial begin
		result_t none;
		logic [TICK_BITS-1:0] phase_gap [5];
		logic [TIME_BITS-1:0] now;
		logic [TIME_BITS-1:0] t;
		int r;
		none = mk(KIND_ACK, 1'b0, '0, '0, 1'b0, '0, 1'b0);
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_SCHEDULE;
		in_ch.event_id = '0;
		in_ch.time_value = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		table_q = {table_q, row(CMD_TICK, 8'd0, '0, 1'b1,
			mk(KIND_WAKE, 1'b0, '0, '0, 1'b0, '0, 1'b1))};
		table_q = {table_q, row(CMD_SCHEDULE, 8'd0, '0, 1'b1,
			mk(KIND_ACK, 1'b0, '0, '0, 1'b1, '0, 1'b1))};
		table_q = {table_q, row(CMD_SCHEDULE, 8'hFF, TIME_MAX, 1'b0, none)};
		table_q = {table_q, row(CMD_TICK, 8'd0, 48'd1, 1'b0, none)};
		for (int i = 1; i <= 15; i++)
			table_q = {table_q, row(CMD_SCHEDULE, 8'(i), 48'd100, 1'b0, none)};
		table_q = {table_q, row(CMD_SCHEDULE, 8'hAA, 48'd5, 1'b1,
			mk(KIND_ACK, 1'b1, '0, '0, 1'b0, '0, 1'b1))};
		table_q = {table_q, row(CMD_TICK, 8'hFF, TIME_MAX, 1'b0, none)};
		foreach (table_q[i])
			send(table_q[i].cmd, table_q[i].id, table_q[i].t, table_q[i].typed,
				table_q[i].want);

		// zero report with a non-empty queue
		settle_and_set('0);
		send(CMD_SCHEDULE, 8'h5A, '0, 1'b0, none);
		send(CMD_TICK, 8'h00, '0, 1'b0, none);
		send(CMD_TICK, 8'h00, 48'd1, 1'b0, none);

		phase_gap[0] = 32'hFFFF_FFFF;
		phase_gap[1] = '0;
		phase_gap[2] = $urandom;
		phase_gap[3] = 32'd1;
		phase_gap[4] = TICK_RESET;
		now = '0;
		for (int p = 0; p < 5; p++) begin
			settle_and_set(phase_gap[p]);
			if (p == 1) hold_req = 1'b1;
			if (p == 4) quiet = 1'b1;
			for (int n = 0; n < 92; n++) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					t = add_sat(now, TICK_BITS'($urandom_range(0, 3000)));
					send(CMD_SCHEDULE, 8'($urandom), t, 1'b0, none);
				end else if (r < 85) begin
					now = add_sat(now, TICK_BITS'($urandom_range(0, 2500)));
					send(CMD_TICK, 8'($urandom), now, 1'b0, none);
				end else if (r < 93) begin
					t = TIME_BITS'({$urandom, $urandom});
					send(CMD_SCHEDULE, 8'($urandom), t, 1'b0, none);
				end else begin
					t = TIME_BITS'({$urandom, $urandom});
					send(CMD_TICK, 8'($urandom), t, 1'b0, none);
				end
			end
		end

		in_ch.valid = 1'b0;
		wait (expected_q.size() == 0);
		repeat (20) @(negedge clk);
		$display("covered %0d inputs, %0d results, %0d fired events, %0d full-queue rejects",
			items_sent, results_seen, fired_seen, rejects_seen);
		$display("tick lengths swept from 0 to all ones, with one long receiver hold-off");
		if (errors == 0 && expected_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
`default_nettype wire
